### rtl/core/mcbs_pkg.sv
// Shared types and shift-line operation codes for the bar smoother.
`timescale 1ns / 1ps

package mcbs_pkg;

    typedef logic [1:0] mcbs_op_t;

    localparam mcbs_op_t OP_HOLD = 2'd0;
    localparam mcbs_op_t OP_PUSH = 2'd1;
    localparam mcbs_op_t OP_POP  = 2'd2;
    localparam mcbs_op_t OP_COPY = 2'd3;

    typedef struct packed {
        mcbs_op_t b_op;
        mcbs_op_t a_op;
        mcbs_op_t p_op;
    } mcbs_ctrl_t;

endpackage

### rtl/core/mcbs_cell.sv
// One cell of the bar shift lines: raw stack, work line and previous-frame line.
`timescale 1ns / 1ps

module mcbs_cell
    import mcbs_pkg::*;
#(
    parameter int LEVEL_BITS = 16
)
(
    input  logic                  clk,
    input  mcbs_ctrl_t            ctrl,
    input  logic                  is_tail,
    input  logic [LEVEL_BITS-1:0] b_below,
    input  logic [LEVEL_BITS-1:0] b_above,
    input  logic [LEVEL_BITS-1:0] a_lvl_below,
    input  logic [LEVEL_BITS-1:0] a_aux_below,
    input  logic [LEVEL_BITS-1:0] a_lvl_above,
    input  logic [LEVEL_BITS-1:0] a_aux_above,
    input  logic [LEVEL_BITS-1:0] a_lvl_new,
    input  logic [LEVEL_BITS-1:0] a_aux_new,
    input  logic [LEVEL_BITS-1:0] p_above,
    input  logic [LEVEL_BITS-1:0] p_new,
    output logic [LEVEL_BITS-1:0] b_q,
    output logic [LEVEL_BITS-1:0] a_lvl_q,
    output logic [LEVEL_BITS-1:0] a_aux_q,
    output logic [LEVEL_BITS-1:0] p_q
);

    logic [LEVEL_BITS-1:0] b_reg;
    logic [LEVEL_BITS-1:0] b_next;
    logic [LEVEL_BITS-1:0] a_lvl_reg;
    logic [LEVEL_BITS-1:0] a_lvl_next;
    logic [LEVEL_BITS-1:0] a_aux_reg;
    logic [LEVEL_BITS-1:0] a_aux_next;
    logic [LEVEL_BITS-1:0] p_reg;
    logic [LEVEL_BITS-1:0] p_next;

    always_comb
    begin
        case (ctrl.b_op)
            OP_PUSH: b_next = b_below;
            OP_POP:  b_next = b_above;
            default: b_next = b_reg;
        endcase
    end

    always_comb
    begin
        case (ctrl.a_op)
            OP_PUSH:
            begin
                a_lvl_next = a_lvl_below;
                a_aux_next = a_aux_below;
            end
            OP_POP:
            begin
                a_lvl_next = is_tail ? a_lvl_new : a_lvl_above;
                a_aux_next = is_tail ? a_aux_new : a_aux_above;
            end
            default:
            begin
                a_lvl_next = a_lvl_reg;
                a_aux_next = a_aux_reg;
            end
        endcase
    end

    always_comb
    begin
        case (ctrl.p_op)
            OP_POP:  p_next = is_tail ? p_new : p_above;
            OP_COPY: p_next = a_lvl_reg;
            default: p_next = p_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        b_reg     <= b_next;
        a_lvl_reg <= a_lvl_next;
        a_aux_reg <= a_aux_next;
        p_reg     <= p_next;
    end

    assign b_q     = b_reg;
    assign a_lvl_q = a_lvl_reg;
    assign a_aux_q = a_aux_reg;
    assign p_q     = p_reg;

endmodule

### rtl/core/mcbs_decay.sv
// Registered carry decay: floor(carry * 2 / 3) by reciprocal multiply.
`timescale 1ns / 1ps

module mcbs_decay
    import mcbs_pkg::*;
#(
    parameter int LEVEL_BITS = 16
)
(
    input  logic                  clk,
    input  logic [LEVEL_BITS-1:0] carry,
    output logic [LEVEL_BITS-1:0] decayed
);

    localparam int MUL_BITS = LEVEL_BITS + 1;
    localparam int SHIFT    = LEVEL_BITS + 2;
    localparam logic [63:0] MUL_FULL = ((64'd1 << SHIFT) + 64'd2) / 64'd3;
    localparam logic [MUL_BITS-1:0] DECAY_MUL = MUL_FULL[MUL_BITS-1:0];

    logic [LEVEL_BITS+MUL_BITS-1:0] product_reg;
    logic [LEVEL_BITS+MUL_BITS-1:0] product_next;

    assign product_next = (LEVEL_BITS + MUL_BITS)'(carry) * (LEVEL_BITS + MUL_BITS)'(DECAY_MUL);

    always_ff @(posedge clk)
    begin
        product_reg <= product_next;
    end

    assign decayed = product_reg[LEVEL_BITS+MUL_BITS-1:MUL_BITS];

endmodule

### rtl/core/monstercat_bar_smoother.sv
// Monstercat bar smoother top level: frame loader, two decay passes, change check.
`timescale 1ns / 1ps

// Bars enter one per cycle while a frame loads; the block takes no bar from the
// moment the last bar of a frame arrives until that frame is settled. A frame of
// n bars then runs a right-to-left pass and a left-to-right pass, each bar in a
// multiply phase and then a max phase because the decay multiply is registered
// before the max; if the frame differs from the last one sent (or none was sent
// since reset or a bar_count write), a copy step follows and the n results go
// out one per transfer.
// Storage is a row of cells that shift toward or away from cell 0; no clearing
// pass is needed after reset. bar_count of 0 swallows bars; above MAX_BARS it
// acts as MAX_BARS.

module monstercat_bar_smoother
    import mcbs_pkg::*;
#(
    parameter int MAX_BARS   = 64,
    parameter int LEVEL_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_data,
    input  logic        bar_valid,
    output logic        bar_ready,
    input  logic [15:0] bar_magnitude,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [5:0]  bar_index,
    output logic [15:0] smoothed_level,
    output logic        frame_last
);

    localparam int CW = $clog2(MAX_BARS + 1);

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_BWD  = 2'd1;
    localparam logic [1:0] ST_FWD  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic                  phase_reg;
    logic                  phase_next;
    logic                  copy_reg;
    logic                  copy_next;
    logic [CW-1:0]         step_reg;
    logic [CW-1:0]         step_next;
    logic [CW-1:0]         load_pos_reg;
    logic [CW-1:0]         load_pos_next;
    logic [LEVEL_BITS-1:0] carry_reg;
    logic [LEVEL_BITS-1:0] carry_next;
    logic                  changed_reg;
    logic                  changed_next;
    logic                  prev_valid_reg;
    logic                  prev_valid_next;
    logic [6:0]            bar_count_reg;
    logic [6:0]            bar_count_next;

    logic [CW-1:0]         active_n;
    logic [CW-1:0]         last_pos;
    logic                  step_last;
    logic [LEVEL_BITS-1:0] bar_level;
    logic [LEVEL_BITS-1:0] decayed;
    logic [LEVEL_BITS-1:0] bwd_carry;
    logic [LEVEL_BITS-1:0] fwd_carry;
    logic [LEVEL_BITS-1:0] result_lvl;
    mcbs_ctrl_t            ctrl;

    logic [LEVEL_BITS-1:0] b_q     [MAX_BARS];
    logic [LEVEL_BITS-1:0] a_lvl_q [MAX_BARS];
    logic [LEVEL_BITS-1:0] a_aux_q [MAX_BARS];
    logic [LEVEL_BITS-1:0] p_q     [MAX_BARS];

    assign active_n  = (int'(bar_count_reg) > MAX_BARS) ? CW'(MAX_BARS) : CW'(bar_count_reg);
    assign last_pos  = active_n - CW'(1);
    assign step_last = (step_reg == last_pos);
    assign bar_level = LEVEL_BITS'(bar_magnitude);

    assign bwd_carry  = (b_q[0] > decayed) ? b_q[0] : decayed;
    assign fwd_carry  = (a_lvl_q[0] > decayed) ? a_lvl_q[0] : decayed;
    assign result_lvl = (fwd_carry > a_aux_q[0]) ? fwd_carry : a_aux_q[0];

    mcbs_decay #(
        .LEVEL_BITS (LEVEL_BITS)
    ) u_decay (
        .clk     (clk),
        .carry   (carry_reg),
        .decayed (decayed)
    );

    genvar gi;
    generate
        for (gi = 0; gi < MAX_BARS; gi++)
        begin : g_cell
            logic [LEVEL_BITS-1:0] b_below;
            logic [LEVEL_BITS-1:0] b_above;
            logic [LEVEL_BITS-1:0] a_lvl_below;
            logic [LEVEL_BITS-1:0] a_aux_below;
            logic [LEVEL_BITS-1:0] a_lvl_above;
            logic [LEVEL_BITS-1:0] a_aux_above;
            logic [LEVEL_BITS-1:0] p_above;

            if (gi == 0)
            begin : g_first
                assign b_below     = bar_level;
                assign a_lvl_below = b_q[0];
                assign a_aux_below = bwd_carry;
            end
            else
            begin : g_inner
                assign b_below     = b_q[gi-1];
                assign a_lvl_below = a_lvl_q[gi-1];
                assign a_aux_below = a_aux_q[gi-1];
            end

            if (gi == MAX_BARS - 1)
            begin : g_top
                assign b_above     = b_q[gi];
                assign a_lvl_above = a_lvl_q[gi];
                assign a_aux_above = a_aux_q[gi];
                assign p_above     = p_q[gi];
            end
            else
            begin : g_mid
                assign b_above     = b_q[gi+1];
                assign a_lvl_above = a_lvl_q[gi+1];
                assign a_aux_above = a_aux_q[gi+1];
                assign p_above     = p_q[gi+1];
            end

            mcbs_cell #(
                .LEVEL_BITS (LEVEL_BITS)
            ) u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .is_tail     (CW'(gi) == last_pos),
                .b_below     (b_below),
                .b_above     (b_above),
                .a_lvl_below (a_lvl_below),
                .a_aux_below (a_aux_below),
                .a_lvl_above (a_lvl_above),
                .a_aux_above (a_aux_above),
                .a_lvl_new   (result_lvl),
                .a_aux_new   (a_aux_q[0]),
                .p_above     (p_above),
                .p_new       (p_q[0]),
                .b_q         (b_q[gi]),
                .a_lvl_q     (a_lvl_q[gi]),
                .a_aux_q     (a_aux_q[gi]),
                .p_q         (p_q[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        copy_next       = 1'b0;
        step_next       = step_reg;
        load_pos_next   = load_pos_reg;
        carry_next      = carry_reg;
        changed_next    = changed_reg;
        prev_valid_next = prev_valid_reg;
        bar_count_next  = bar_count_reg;
        ctrl.b_op       = OP_HOLD;
        ctrl.a_op       = OP_HOLD;
        ctrl.p_op       = OP_HOLD;
        bar_ready       = 1'b0;
        result_valid    = 1'b0;

        case (state_reg)
            ST_LOAD:
            begin
                bar_ready = 1'b1;
                if (bar_valid && (active_n != '0))
                begin
                    ctrl.b_op = OP_PUSH;
                    if (load_pos_reg + CW'(1) == active_n)
                    begin
                        load_pos_next = '0;
                        state_next    = ST_BWD;
                        phase_next    = 1'b0;
                        step_next     = '0;
                        carry_next    = '0;
                    end
                    else
                    begin
                        load_pos_next = load_pos_reg + CW'(1);
                    end
                end
            end
            ST_BWD:
            begin
                phase_next = ~phase_reg;
                if (phase_reg)
                begin
                    ctrl.b_op  = OP_POP;
                    ctrl.a_op  = OP_PUSH;
                    carry_next = bwd_carry;
                    step_next  = step_reg + CW'(1);
                    if (step_last)
                    begin
                        state_next   = ST_FWD;
                        step_next    = '0;
                        carry_next   = '0;
                        changed_next = ~prev_valid_reg;
                    end
                end
            end
            ST_FWD:
            begin
                phase_next = ~phase_reg;
                if (phase_reg)
                begin
                    ctrl.a_op  = OP_POP;
                    ctrl.p_op  = OP_POP;
                    carry_next = fwd_carry;
                    step_next  = step_reg + CW'(1);
                    if (result_lvl != p_q[0])
                    begin
                        changed_next = 1'b1;
                    end
                    if (step_last)
                    begin
                        step_next = '0;
                        if (changed_reg || (result_lvl != p_q[0]))
                        begin
                            state_next = ST_EMIT;
                            copy_next  = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_LOAD;
                        end
                    end
                end
            end
            ST_EMIT:
            begin
                if (copy_reg)
                begin
                    ctrl.p_op       = OP_COPY;
                    prev_valid_next = 1'b1;
                end
                else
                begin
                    result_valid = 1'b1;
                    if (result_ready)
                    begin
                        ctrl.a_op = OP_POP;
                        step_next = step_reg + CW'(1);
                        if (step_last)
                        begin
                            step_next  = '0;
                            state_next = ST_LOAD;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase

        if (cfg_we)
        begin
            bar_count_next  = cfg_data;
            prev_valid_next = 1'b0;
            load_pos_next   = '0;
            state_next      = ST_LOAD;
            phase_next      = 1'b0;
            copy_next       = 1'b0;
            step_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            phase_reg      <= 1'b0;
            copy_reg       <= 1'b0;
            step_reg       <= '0;
            load_pos_reg   <= '0;
            changed_reg    <= 1'b0;
            prev_valid_reg <= 1'b0;
            bar_count_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            copy_reg       <= copy_next;
            step_reg       <= step_next;
            load_pos_reg   <= load_pos_next;
            changed_reg    <= changed_next;
            prev_valid_reg <= prev_valid_next;
            bar_count_reg  <= bar_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        carry_reg <= carry_next;
    end

    assign bar_index      = 6'(step_reg);
    assign smoothed_level = 16'(a_lvl_q[0]);
    assign frame_last     = step_last;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(bar_ready && result_valid))
        else $error("bar input open while results are pending");

    a_last_closes_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_ready && frame_last && !cfg_we) |=> !result_valid)
        else $error("results continue after the final bar of a frame");

    a_emit_marks_prev: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> prev_valid_reg)
        else $error("frame sent without recording it as previous");

    a_phase_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (state_reg == ST_BWD || state_reg == ST_FWD))
        else $error("decay phase set outside a filter pass");

endmodule

### sim/bar_smoother_checker.sv
// Checker for the bar smoother: tracks frames on the bar channel, predicts and compares results.
`timescale 1ns / 1ps

module bar_smoother_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_data,
    input  logic        bar_valid,
    input  logic        bar_ready,
    input  logic [15:0] bar_magnitude,
    input  logic        result_valid,
    input  logic        result_ready,
    input  logic [5:0]  bar_index,
    input  logic [15:0] smoothed_level,
    input  logic        frame_last,
    output int          fail_count,
    output int          pending
);

    localparam int MAX_BARS = 64;

    typedef struct packed {
        logic [5:0]  index;
        logic [15:0] level;
        logic        last;
    } smoothed_bar_t;

    logic [6:0]    count_reg;
    logic [15:0]   raw_bars [MAX_BARS];
    logic [15:0]   sent_frame [MAX_BARS];
    logic          sent_valid;
    int            load_pos;
    int            mismatches = 0;
    smoothed_bar_t expected_bars [$];

    function automatic logic [15:0] decay_keep(input logic [15:0] level, input logic [15:0] carry);
        logic [16:0] decayed;
        decayed = {carry, 1'b0} / 17'd3;
        return (level > decayed[15:0]) ? level : decayed[15:0];
    endfunction

    task automatic smooth_frame(input int n);
        logic [15:0] merged [MAX_BARS];
        logic [15:0] carry;
        logic        changed;
        carry = '0;
        for (int i = 0; i < n; i++)
        begin
            carry = decay_keep(raw_bars[i], carry);
            merged[i] = carry;
        end
        carry = '0;
        for (int i = n - 1; i >= 0; i--)
        begin
            carry = decay_keep(raw_bars[i], carry);
            if (carry > merged[i])
                merged[i] = carry;
        end
        changed = !sent_valid;
        for (int i = 0; i < n; i++)
        begin
            if (sent_frame[i] != merged[i])
                changed = 1'b1;
        end
        if (changed)
        begin
            for (int i = 0; i < n; i++)
            begin
                sent_frame[i] = merged[i];
                expected_bars.push_back('{index: 6'(i), level: merged[i], last: (i == n - 1)});
            end
            sent_valid = 1'b1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        smoothed_bar_t want;
        int            n;
        if (!rst_n)
        begin
            count_reg = '0;
            sent_valid = 1'b0;
            load_pos = 0;
            expected_bars.delete();
            pending <= 0;
            fail_count <= mismatches;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_bars.size() == 0)
                begin
                    $error("unexpected result transfer: bar_index %0d, smoothed_level %0h",
                           bar_index, smoothed_level);
                    mismatches++;
                end
                else
                begin
                    want = expected_bars.pop_front();
                    if (bar_index !== want.index)
                    begin
                        $error("bar_index: expected %0d, got %0d", want.index, bar_index);
                        mismatches++;
                    end
                    if (smoothed_level !== want.level)
                    begin
                        $error("smoothed_level: expected %0h, got %0h", want.level, smoothed_level);
                        mismatches++;
                    end
                    if (frame_last !== want.last)
                    begin
                        $error("frame_last: expected %0b, got %0b", want.last, frame_last);
                        mismatches++;
                    end
                end
            end

            if (cfg_we)
            begin
                count_reg = cfg_data;
                sent_valid = 1'b0;
                load_pos = 0;
            end

            n = (count_reg > MAX_BARS) ? MAX_BARS : int'(count_reg);
            if (bar_valid && bar_ready && n != 0)
            begin
                if (load_pos >= n)
                    load_pos = 0;
                raw_bars[load_pos] = bar_magnitude;
                load_pos++;
                if (load_pos >= n)
                begin
                    load_pos = 0;
                    smooth_frame(n);
                end
            end

            pending <= expected_bars.size();
            fail_count <= mismatches;
        end
    end

endmodule

### sim/tb_monstercat_bar_smoother.sv
// Testbench top for the bar smoother: clock, reset, bar and result traffic, verdict.
`timescale 1ns / 1ps

module tb_monstercat_bar_smoother;

    localparam int SETTLE_CYCLES = 400;
    localparam int HOLD_CYCLES   = 1500;
    localparam int QUIET_LIMIT   = 20000;
    localparam int RANDOM_BARS   = 200;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [6:0]  cfg_data;
    logic        bar_valid;
    logic        bar_ready;
    logic [15:0] bar_magnitude;
    logic        result_valid;
    logic        result_ready;
    logic [5:0]  bar_index;
    logic [15:0] smoothed_level;
    logic        frame_last;
    logic        hold_req;

    int          fail_count;
    int          pending;
    int          quiet_cycles = 0;
    int          sent_bars = 0;
    int          random_bars = 0;
    int          frame_len = 0;
    logic [15:0] frame_buf [64];

    monstercat_bar_smoother dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .bar_valid      (bar_valid),
        .bar_ready      (bar_ready),
        .bar_magnitude  (bar_magnitude),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .bar_index      (bar_index),
        .smoothed_level (smoothed_level),
        .frame_last     (frame_last)
    );

    bar_smoother_checker u_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .bar_valid      (bar_valid),
        .bar_ready      (bar_ready),
        .bar_magnitude  (bar_magnitude),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .bar_index      (bar_index),
        .smoothed_level (smoothed_level),
        .frame_last     (frame_last),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((bar_valid && bar_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("** monstercat_bar_smoother: FAILED **");
            $finish;
        end
    end

    initial
    begin
        int rx_cycle;
        int hold_done;
        rx_cycle = 0;
        hold_done = 0;
        result_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            rx_cycle++;
            if (hold_req && hold_done == 0)
            begin
                hold_done = 1;
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (rx_cycle >= 4000 && rx_cycle < 9000)
                result_ready <= 1'b1;
            else
                result_ready <= ($urandom_range(0, 99) >= 19);
        end
    end

    task automatic send_bar(input logic [15:0] level);
        int gap;
        if ($urandom_range(0, 99) < 19 && !(sent_bars >= 260 && sent_bars < 380))
        begin
            gap = $urandom_range(1, 3);
            bar_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        bar_valid <= 1'b1;
        bar_magnitude <= level;
        do
            @(posedge clk);
        while (!bar_ready);
        sent_bars++;
    endtask

    task automatic settle();
        bar_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_count(input logic [6:0] count);
        cfg_we <= 1'b1;
        cfg_data <= count;
        @(posedge clk);
        cfg_we <= 1'b0;
        frame_len = (count > 7'd64) ? 64 : int'(count);
    endtask

    task automatic fill_frame();
        int mode;
        mode = $urandom_range(0, 3);
        for (int i = 0; i < frame_len; i++)
        begin
            case (mode)
                2:       frame_buf[i] = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'h0000;
                3:       frame_buf[i] = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(0, 4));
                default: frame_buf[i] = 16'($urandom);
            endcase
        end
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_len; i++)
            send_bar(frame_buf[i]);
        random_bars += frame_len;
    endtask

    initial
    begin
        int pick;
        int count;
        int frames;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_data <= '0;
        bar_valid <= 1'b0;
        bar_magnitude <= '0;
        hold_req <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // disabled after reset: bars are swallowed
        send_bar(16'hFFFF);
        send_bar(16'h0000);
        settle();

        write_count(7'd1);
        send_bar(16'hFFFF);
        send_bar(16'hFFFF);
        send_bar(16'h0000);
        settle();

        write_count(7'd3);
        send_bar(16'hFFFF);
        send_bar(16'h0000);
        send_bar(16'h0000);
        send_bar(16'h0000);
        send_bar(16'h0000);
        send_bar(16'hFFFF);
        send_bar(16'h0000);
        send_bar(16'h0000);
        send_bar(16'hFFFF);
        settle();

        // drop a partly loaded frame with a rewrite
        send_bar(16'h8000);
        send_bar(16'h1234);
        settle();
        write_count(7'd3);
        send_bar(16'h0001);
        send_bar(16'h0003);
        send_bar(16'h0002);
        settle();

        // full frames with the receiver held off
        write_count(7'd64);
        hold_req <= 1'b1;
        repeat (2)
        begin
            fill_frame();
            send_frame();
        end
        settle();

        write_count(7'd127);
        fill_frame();
        send_frame();
        send_frame();
        settle();

        random_bars = 0;
        while (random_bars < RANDOM_BARS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
                count = 0;
            else if (pick < 10)
                count = $urandom_range(9, 127);
            else
                count = $urandom_range(1, 8);
            write_count(7'(count));
            if (frame_len == 0)
            begin
                repeat (3) send_bar(16'($urandom));
            end
            else
            begin
                frames = $urandom_range(2, 6);
                repeat (frames)
                begin
                    if ($urandom_range(0, 3) != 0)
                        fill_frame();
                    send_frame();
                end
                if (frame_len > 1 && $urandom_range(0, 6) == 0)
                begin
                    repeat ($urandom_range(1, frame_len - 1)) send_bar(16'($urandom));
                end
            end
            settle();
        end

        if (fail_count == 0 && pending == 0)
            $display("** monstercat_bar_smoother: PASSED **");
        else
            $display("** monstercat_bar_smoother: FAILED **");
        $finish;
    end

endmodule
